### hdl/led_bitcell_symbol_encoder_macros.svh
// assertion macros for the led bit-cell symbol encoder
`ifndef LED_BITCELL_SYMBOL_ENCODER_MACROS_SVH
`define LED_BITCELL_SYMBOL_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

`define LBSE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbse assertion failed");

`define LBSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbse assertion failed");

`else

`define LBSE_ASSERT_SAME(lbl, ante, cons)

`define LBSE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hdl/lbse_pkg.sv
// shared types and constants for the led bit-cell symbol encoder
`timescale 1ns / 1ps

package lbse_pkg;

    localparam int TICK_W  = 15;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 3;

    localparam logic [INDEX_W-1:0] REG_BRIGHTNESS  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_ZERO_HIGH   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_ZERO_LOW    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_ONE_HIGH    = 3'd3;
    localparam logic [INDEX_W-1:0] REG_ONE_LOW     = 3'd4;
    localparam logic [INDEX_W-1:0] REG_RESET_HALF  = 3'd5;

    localparam logic [BYTE_W-1:0] BRIGHTNESS_RST  = 8'd255;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST   = 15'd7;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST    = 15'd18;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST    = 15'd14;
    localparam logic [TICK_W-1:0] ONE_LOW_RST     = 15'd11;
    localparam logic [TICK_W-1:0] RESET_HALF_RST  = 15'd2500;

    localparam logic [15:0] ROUND_BIAS = 16'd127;

    // symbol counter value of the reset symbol
    localparam logic [3:0] SYM_RESET = 4'd8;
    localparam logic [3:0] SYM_LAST_BIT = 4'd7;

    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] reset_half;
    } lbse_timing_t;

    typedef struct packed {
        logic [BYTE_W-1:0] scaled;
        logic              frame_end;
    } lbse_item_t;

    typedef struct packed {
        logic [TICK_W-1:0] first_ticks;
        logic              first_level;
        logic [TICK_W-1:0] second_ticks;
        logic              last_of_run;
    } lbse_symbol_t;

endpackage

### hdl/led_bitcell_symbol_encoder.sv
// top level of the led bit-cell symbol encoder
//
//   channel   handshake      payload
//   input     push / full    color_byte, frame_end
//   result    empty / pop    first_ticks, first_level, second_ticks,
//                            second_level, last_of_run
//   config    cfg_we         cfg_index, cfg_data
//
// one symbol per cycle from the back end's output register while pop keeps taking
// them: 8 bit symbols per item, plus a reset symbol with frame_end; the symbol sequencer sets the rate
// after acceptance an item passes the front product register, the queue write, the
// sequencer load and the output register before its first symbol reaches the result ports
// reset clears all control state and loads the register defaults
// a stalled pop holds the back end; the queue lets the front keep taking items
`timescale 1ns / 1ps

`include "led_bitcell_symbol_encoder_macros.svh"

module led_bitcell_symbol_encoder import lbse_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]  cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [BYTE_W-1:0]  color_byte,
    input  logic               frame_end,
    output logic               empty,
    input  logic               pop,
    output logic [TICK_W-1:0]  first_ticks,
    output logic               first_level,
    output logic [TICK_W-1:0]  second_ticks,
    output logic               second_level,
    output logic               last_of_run
);

    logic [BYTE_W-1:0] brightness_reg;
    logic [BYTE_W-1:0] brightness_next;
    lbse_timing_t      timing_reg;
    lbse_timing_t      timing_next;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    lbse_item_t        front_item;
    lbse_item_t        back_item;
    lbse_symbol_t      sym;

    always_comb
    begin
        brightness_next = brightness_reg;
        timing_next     = timing_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BRIGHTNESS: brightness_next       = cfg_data[BYTE_W-1:0];
                REG_ZERO_HIGH:  timing_next.zero_high  = cfg_data;
                REG_ZERO_LOW:   timing_next.zero_low   = cfg_data;
                REG_ONE_HIGH:   timing_next.one_high   = cfg_data;
                REG_ONE_LOW:    timing_next.one_low    = cfg_data;
                REG_RESET_HALF: timing_next.reset_half = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg        <= BRIGHTNESS_RST;
            timing_reg.zero_high  <= ZERO_HIGH_RST;
            timing_reg.zero_low   <= ZERO_LOW_RST;
            timing_reg.one_high   <= ONE_HIGH_RST;
            timing_reg.one_low    <= ONE_LOW_RST;
            timing_reg.reset_half <= RESET_HALF_RST;
        end
        else
        begin
            brightness_reg <= brightness_next;
            timing_reg     <= timing_next;
        end
    end

    lbse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .brightness (brightness_reg),
        .push       (push),
        .full       (full),
        .color_byte (color_byte),
        .frame_end  (frame_end),
        .q_push     (q_push),
        .q_item     (front_item),
        .q_full     (q_full)
    );

    lbse_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_item (front_item),
        .q_full  (q_full),
        .rd      (q_pop),
        .rd_item (back_item),
        .q_valid (q_valid)
    );

    lbse_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .timing  (timing_reg),
        .q_valid (q_valid),
        .q_item  (back_item),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .sym     (sym)
    );

    assign first_ticks  = sym.first_ticks;
    assign first_level  = sym.first_level;
    assign second_ticks = sym.second_ticks;
    assign second_level = 1'b0;
    assign last_of_run  = sym.last_of_run;

    `LBSE_ASSERT_SAME(a_reset_sym_last, !empty && !first_level, last_of_run)
    `LBSE_ASSERT_NEXT(a_no_double_reset, !empty && pop && !first_level, empty || first_level)
    `LBSE_ASSERT_SAME(a_pop_needs_item, q_pop, q_valid)
    `LBSE_ASSERT_SAME(a_push_has_room, q_push, !q_full)

endmodule

### hdl/lbse_front.sv
// front end: scales the color byte by brightness with rounding
`timescale 1ns / 1ps

module lbse_front import lbse_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BYTE_W-1:0] brightness,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] color_byte,
    input  logic              frame_end,
    output logic              q_push,
    output lbse_item_t        q_item,
    input  logic              q_full
);

    logic [15:0] prod_reg;
    logic [15:0] prod_next;
    logic        end_reg;
    logic        end_next;
    logic        valid_reg;
    logic        valid_next;
    logic        advance;
    logic [15:0] biased;
    logic [15:0] rounded;

    assign advance = !valid_reg || !q_full;
    assign full    = !advance;
    assign q_push  = valid_reg && !q_full;

    // divide by 255: (x + 1 + (x >> 8)) >> 8, exact below 65535
    assign biased  = prod_reg + ROUND_BIAS;
    assign rounded = biased + 16'd1 + {8'd0, biased[15:8]};

    assign q_item.scaled    = rounded[15:8];
    assign q_item.frame_end = end_reg;

    always_comb
    begin
        prod_next  = prod_reg;
        end_next   = end_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = push;
            prod_next  = {8'd0, color_byte} * {8'd0, brightness};
            end_next   = frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        end_reg  <= end_next;
    end

endmodule

### hdl/lbse_queue.sv
// two-entry queue between front and back
`timescale 1ns / 1ps

module lbse_queue import lbse_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr,
    input  lbse_item_t wr_item,
    output logic       q_full,
    input  logic       rd,
    output lbse_item_t rd_item,
    output logic       q_valid
);

    lbse_item_t  slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_wr;
    logic        do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign rd_item = slot_reg[rd_ptr_reg];
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && q_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### hdl/lbse_back.sv
// back end: steps through the symbols of one item into the output register
`timescale 1ns / 1ps

module lbse_back import lbse_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  lbse_timing_t timing,
    input  logic         q_valid,
    input  lbse_item_t   q_item,
    output logic         q_pop,
    input  logic         pop,
    output logic         empty,
    output lbse_symbol_t sym
);

    lbse_item_t   cur_reg;
    lbse_item_t   cur_next;
    logic [3:0]   cnt_reg;
    logic [3:0]   cnt_next;
    logic         busy_reg;
    logic         busy_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    lbse_symbol_t sym_reg;
    lbse_symbol_t sym_next;
    lbse_symbol_t gen_sym;
    logic         load_ok;
    logic         gen;
    logic         final_sym;
    logic         bit_val;

    assign load_ok   = !out_valid_reg || pop;
    assign gen       = busy_reg && load_ok;
    assign final_sym = gen && ((cnt_reg == SYM_LAST_BIT && !cur_reg.frame_end)
                               || cnt_reg == SYM_RESET);
    assign q_pop     = q_valid && (!busy_reg || final_sym);
    assign bit_val   = cur_reg.scaled[~cnt_reg[2:0]];

    always_comb
    begin
        if (cnt_reg == SYM_RESET)
        begin
            gen_sym.first_ticks  = timing.reset_half;
            gen_sym.first_level  = 1'b0;
            gen_sym.second_ticks = timing.reset_half;
            gen_sym.last_of_run  = 1'b1;
        end
        else
        begin
            gen_sym.first_ticks  = bit_val ? timing.one_high : timing.zero_high;
            gen_sym.first_level  = 1'b1;
            gen_sym.second_ticks = bit_val ? timing.one_low : timing.zero_low;
            gen_sym.last_of_run  = (cnt_reg == SYM_LAST_BIT) && !cur_reg.frame_end;
        end
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        sym_next       = sym_reg;
        out_valid_next = out_valid_reg && !pop;
        if (gen)
        begin
            sym_next       = gen_sym;
            out_valid_next = 1'b1;
            cnt_next       = cnt_reg + 4'd1;
            if (final_sym)
            begin
                busy_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            cur_next  = q_item;
            cnt_next  = 4'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 4'd0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        sym_reg <= sym_next;
    end

    assign empty = !out_valid_reg;
    assign sym   = sym_reg;

endmodule
